[design/s2chd_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2chd_pkg
// Shared types and codes for the SSLv2 ClientHello header detector.
// ----------------------------------------------------------------------------
package s2chd_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned REM_W     = 15;
  localparam int unsigned VERDICT_W = 2;

  localparam logic [VERDICT_W-1:0] VERDICT_PENDING   = 2'd0;
  localparam logic [VERDICT_W-1:0] VERDICT_FOUND     = 2'd1;
  localparam logic [VERDICT_W-1:0] VERDICT_NOT_FOUND = 2'd2;

  localparam logic [BYTE_W-1:0] REC_TOP_BIT   = 8'h80;
  localparam logic [BYTE_W-1:0] MSG_CLIENT_HI = 8'h01;
  localparam logic [BYTE_W-1:0] VER_MAX       = 8'h03;
  localparam logic [REM_W:0]    HDR_LEN       = 16'd9;

  // header byte expected next, plus the two final verdicts
  typedef enum logic [12:0] {
    POS_LEN_HI    = 13'b0000000000001,
    POS_LEN_LO    = 13'b0000000000010,
    POS_MSG_TYPE  = 13'b0000000000100,
    POS_VER_MAJ   = 13'b0000000001000,
    POS_VER_MIN   = 13'b0000000010000,
    POS_CS_HI     = 13'b0000000100000,
    POS_CS_LO     = 13'b0000001000000,
    POS_SID_HI    = 13'b0000010000000,
    POS_SID_LO    = 13'b0000100000000,
    POS_CHAL_HI   = 13'b0001000000000,
    POS_CHAL_LO   = 13'b0010000000000,
    POS_FOUND     = 13'b0100000000000,
    POS_NOT_FOUND = 13'b1000000000000
  } pos_t;

  // one byte handed to the parser
  typedef struct packed {
    logic              step;
    logic [BYTE_W-1:0] data_byte;
    logic              new_flow;
  } parse_req_t;

endpackage

[design/s2chd_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2chd_in_if / s2chd_out_if
// Valid/ready channels for payload bytes and verdicts.
// ----------------------------------------------------------------------------
interface s2chd_in_if;
  logic                           valid;
  logic                           ready;
  logic [s2chd_pkg::BYTE_W-1:0]   data_byte;
  logic                           new_flow;
  logic                           segment_end;

  modport source (output valid, output data_byte, output new_flow, output segment_end,
                  input ready);
  modport sink   (input valid, input data_byte, input new_flow, input segment_end,
                  output ready);
endinterface

interface s2chd_out_if;
  logic                             valid;
  logic                             ready;
  logic [s2chd_pkg::VERDICT_W-1:0]  verdict;
  logic                             segment_last;

  modport source (output valid, output verdict, output segment_last, input ready);
  modport sink   (input valid, input verdict, input segment_last, output ready);
endinterface

[design/s2chd_parser.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s2chd_parser
// Header parse state and the per-byte checks; gives the verdict after a byte.
// ----------------------------------------------------------------------------
module s2chd_parser (
  input  logic                               clk,
  input  logic                               rst_n,
  input  s2chd_pkg::parse_req_t              req,
  output logic [s2chd_pkg::VERDICT_W-1:0]    verdict
);

  s2chd_pkg::pos_t                    pos_r, pos_nxt, cur_pos;
  logic [s2chd_pkg::REM_W-1:0]        rem_r, rem_nxt, cur_rem;
  logic [s2chd_pkg::BYTE_W-1:0]       fhi_r, fhi_nxt, cur_fhi;
  logic [s2chd_pkg::REM_W:0]          rec_len;
  logic [s2chd_pkg::REM_W:0]          fld_len;
  logic [s2chd_pkg::REM_W:0]          rem_ext;
  logic                               fits;
  logic [s2chd_pkg::BYTE_W-1:0]       b;

  assign b = req.data_byte;

  // new flow restarts parsing before this byte is handled
  assign cur_pos = req.new_flow ? s2chd_pkg::POS_LEN_HI : pos_r;
  assign cur_rem = req.new_flow ? '0 : rem_r;
  assign cur_fhi = req.new_flow ? '0 : fhi_r;

  assign rec_len = {1'b0, cur_rem[s2chd_pkg::REM_W-1:s2chd_pkg::BYTE_W], b};
  assign fld_len = {cur_fhi, b};
  assign rem_ext = {1'b0, cur_rem};
  assign fits    = (rem_ext >= fld_len);

  always_comb begin
    pos_nxt = cur_pos;
    rem_nxt = cur_rem;
    fhi_nxt = cur_fhi;
    case (cur_pos)
      s2chd_pkg::POS_LEN_HI: begin
        if ((b & s2chd_pkg::REC_TOP_BIT) == '0) begin
          pos_nxt = s2chd_pkg::POS_NOT_FOUND;
        end else begin
          rem_nxt = {b[s2chd_pkg::BYTE_W-2:0], {s2chd_pkg::BYTE_W{1'b0}}};
          pos_nxt = s2chd_pkg::POS_LEN_LO;
        end
      end
      s2chd_pkg::POS_LEN_LO: begin
        if (rec_len < s2chd_pkg::HDR_LEN) begin
          rem_nxt = rec_len[s2chd_pkg::REM_W-1:0];
          pos_nxt = s2chd_pkg::POS_NOT_FOUND;
        end else begin
          rem_nxt = rec_len[s2chd_pkg::REM_W-1:0] - s2chd_pkg::HDR_LEN[s2chd_pkg::REM_W-1:0];
          pos_nxt = s2chd_pkg::POS_MSG_TYPE;
        end
      end
      s2chd_pkg::POS_MSG_TYPE: begin
        pos_nxt = (b == s2chd_pkg::MSG_CLIENT_HI) ? s2chd_pkg::POS_VER_MAJ
                                                  : s2chd_pkg::POS_NOT_FOUND;
      end
      s2chd_pkg::POS_VER_MAJ: begin
        pos_nxt = (b <= s2chd_pkg::VER_MAX) ? s2chd_pkg::POS_VER_MIN
                                            : s2chd_pkg::POS_NOT_FOUND;
      end
      s2chd_pkg::POS_VER_MIN: begin
        pos_nxt = (b <= s2chd_pkg::VER_MAX) ? s2chd_pkg::POS_CS_HI
                                            : s2chd_pkg::POS_NOT_FOUND;
      end
      s2chd_pkg::POS_CS_HI: begin
        fhi_nxt = b;
        pos_nxt = s2chd_pkg::POS_CS_LO;
      end
      s2chd_pkg::POS_SID_HI: begin
        fhi_nxt = b;
        pos_nxt = s2chd_pkg::POS_SID_LO;
      end
      s2chd_pkg::POS_CHAL_HI: begin
        fhi_nxt = b;
        pos_nxt = s2chd_pkg::POS_CHAL_LO;
      end
      s2chd_pkg::POS_CS_LO: begin
        if (fits) begin
          rem_nxt = cur_rem - fld_len[s2chd_pkg::REM_W-1:0];
          pos_nxt = s2chd_pkg::POS_SID_HI;
        end else begin
          pos_nxt = s2chd_pkg::POS_NOT_FOUND;
        end
      end
      s2chd_pkg::POS_SID_LO: begin
        if (fits) begin
          rem_nxt = cur_rem - fld_len[s2chd_pkg::REM_W-1:0];
          pos_nxt = s2chd_pkg::POS_CHAL_HI;
        end else begin
          pos_nxt = s2chd_pkg::POS_NOT_FOUND;
        end
      end
      s2chd_pkg::POS_CHAL_LO: begin
        pos_nxt = fits ? s2chd_pkg::POS_FOUND : s2chd_pkg::POS_NOT_FOUND;
      end
      s2chd_pkg::POS_FOUND: begin
        pos_nxt = s2chd_pkg::POS_FOUND;
      end
      default: begin
        pos_nxt = s2chd_pkg::POS_NOT_FOUND;
      end
    endcase
  end

  always_comb begin
    case (pos_nxt)
      s2chd_pkg::POS_FOUND:     verdict = s2chd_pkg::VERDICT_FOUND;
      s2chd_pkg::POS_NOT_FOUND: verdict = s2chd_pkg::VERDICT_NOT_FOUND;
      default:                  verdict = s2chd_pkg::VERDICT_PENDING;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r <= s2chd_pkg::POS_LEN_HI;
      rem_r <= '0;
      fhi_r <= '0;
    end else if (req.step) begin
      pos_r <= pos_nxt;
      rem_r <= rem_nxt;
      fhi_r <= fhi_nxt;
    end
  end

  // final verdicts are sticky until a new flow
  a_found_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (req.step && !req.new_flow && pos_r == s2chd_pkg::POS_FOUND)
      |=> pos_r == s2chd_pkg::POS_FOUND)
    else $error("found verdict not held");

  a_miss_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    (req.step && !req.new_flow && pos_r == s2chd_pkg::POS_NOT_FOUND)
      |=> pos_r == s2chd_pkg::POS_NOT_FOUND)
    else $error("not-found verdict not held");

  a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
    (req.step && req.new_flow && !req.data_byte[s2chd_pkg::BYTE_W-1])
      |=> pos_r == s2chd_pkg::POS_NOT_FOUND)
    else $error("first byte without top bit not rejected");

endmodule

[design/sslv2_client_hello_detector.sv]
`timescale 1ns / 1ps
// path: a transferred byte is held in the input register, then parsed into the result
//   register once that register frees up; its verdict is then valid at the output
// throughput: one byte per cycle while the output channel is ready or empty
// reset: synchronous rst_n clears both valid flags and returns the parser to
//   the first header byte
// ----------------------------------------------------------------------------
// sslv2_client_hello_detector
// Byte-stream check for an SSLv2 ClientHello record header at flow start.
// ----------------------------------------------------------------------------
module sslv2_client_hello_detector (
  input  logic              clk,
  input  logic              rst_n,
  s2chd_in_if.sink          in_chan,
  s2chd_out_if.source       out_chan
);

  logic                               s1_vld_r;
  logic [s2chd_pkg::BYTE_W-1:0]       s1_byte_r;
  logic                               s1_nf_r;
  logic                               s1_seg_r;
  logic                               out_vld_r;
  logic [s2chd_pkg::VERDICT_W-1:0]    out_verdict_r;
  logic                               out_seg_r;
  logic                               adv;
  logic                               in_xfer;
  s2chd_pkg::parse_req_t              req;
  logic [s2chd_pkg::VERDICT_W-1:0]    verdict_nxt;

  // the result register frees up when empty or when its transfer completes
  assign adv     = !out_vld_r || out_chan.ready;
  assign in_chan.ready = !s1_vld_r || adv;
  assign in_xfer = in_chan.valid && in_chan.ready;

  assign req.step      = s1_vld_r && adv;
  assign req.data_byte = s1_byte_r;
  assign req.new_flow  = s1_nf_r;

  s2chd_parser u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (req),
    .verdict (verdict_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      if (in_chan.ready) begin
        s1_vld_r <= in_chan.valid;
      end
      if (adv) begin
        out_vld_r <= s1_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_byte_r <= in_chan.data_byte;
      s1_nf_r   <= in_chan.new_flow;
      s1_seg_r  <= in_chan.segment_end;
    end
    if (req.step) begin
      out_verdict_r <= verdict_nxt;
      out_seg_r     <= s1_seg_r;
    end
  end

  assign out_chan.valid        = out_vld_r;
  assign out_chan.verdict      = out_verdict_r;
  assign out_chan.segment_last = out_seg_r;

  a_in_lands: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> s1_vld_r)
    else $error("transferred byte lost in input register");

  a_step_lands: assert property (@(posedge clk) disable iff (!rst_n)
    req.step |=> out_vld_r)
    else $error("parsed byte produced no result");

  a_drain: assert property (@(posedge clk) disable iff (!rst_n)
    (!s1_vld_r && out_chan.ready) |=> !out_vld_r)
    else $error("result repeated after its transfer");

endmodule
